>>> sv/kf2s_pkg.sv
// Package for the two-state Kalman filter step: payload structs, state and operation
// codes, operand codes and the microprogram that the sequencer steps through.
// Depends on nothing; used by kalman_filter_two_state_step.
package kf2s_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 28;
   localparam int CFG_WIDTH  = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int TMP_DEPTH  = 32;
   localparam int TMP_AW     = $clog2(TMP_DEPTH);
   localparam int SRC_W      = TMP_AW + 1;
   localparam int PC_W       = 7;
   localparam int DIV_STEPS  = DATA_WIDTH + FRAC_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   typedef logic signed [DATA_WIDTH-1:0] val_type;
   typedef logic [SRC_W-1:0]             src_type;
   typedef logic [PC_W-1:0]              pc_type;

   typedef struct packed {
      logic                    mode;
      logic signed [31:0]      measurement;
      logic signed [31:0]      init_first;
      logic signed [31:0]      init_second;
      logic signed [31:0]      init_cov_11;
      logic signed [31:0]      init_cov_12;
      logic signed [31:0]      init_cov_21;
      logic signed [31:0]      init_cov_22;
   } req_type;

   typedef struct packed {
      logic signed [31:0]      est_first;
      logic signed [31:0]      est_second;
      logic signed [31:0]      out_cov_11;
      logic signed [31:0]      out_cov_12;
      logic signed [31:0]      out_cov_21;
      logic signed [31:0]      out_cov_22;
      logic                    div_fault;
      logic                    saturated;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RD, ST_EX, ST_DIV, ST_WB, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_MUL, OP_ADD, OP_SUB, OP_DIV, OP_CHK
   } op_type;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TRANS_ROW_FIRST  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANS_ROW_SECOND = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OBS_GAINS        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROC_NOISE_DIAG  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PROC_NOISE_CROSS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_NOISE       = 3'd5;

   // Operand codes below TMP_DEPTH address the scratch memory.
   localparam src_type T_M0  = 6'd0;
   localparam src_type T_M1  = 6'd1;
   localparam src_type T_DT  = 6'd2;
   localparam src_type T_XP1 = 6'd3;
   localparam src_type T_XP2 = 6'd4;
   localparam src_type T_M11 = 6'd5;
   localparam src_type T_M12 = 6'd6;
   localparam src_type T_M21 = 6'd7;
   localparam src_type T_M22 = 6'd8;
   localparam src_type T_P11 = 6'd9;
   localparam src_type T_P12 = 6'd10;
   localparam src_type T_P21 = 6'd11;
   localparam src_type T_P22 = 6'd12;
   localparam src_type T_U1  = 6'd13;
   localparam src_type T_U2  = 6'd14;
   localparam src_type T_S   = 6'd15;
   localparam src_type T_K1  = 6'd16;
   localparam src_type T_K2  = 6'd17;
   localparam src_type T_HX  = 6'd18;
   localparam src_type T_INN = 6'd19;
   localparam src_type T_I11 = 6'd20;
   localparam src_type T_I12 = 6'd21;
   localparam src_type T_I21 = 6'd22;
   localparam src_type T_I22 = 6'd23;
   // Operand codes from TMP_DEPTH upwards name registers and constants of the block.
   localparam src_type S_A11  = 6'd32;
   localparam src_type S_A12  = 6'd33;
   localparam src_type S_A21  = 6'd34;
   localparam src_type S_A22  = 6'd35;
   localparam src_type S_H1   = 6'd36;
   localparam src_type S_H2   = 6'd37;
   localparam src_type S_Q11  = 6'd38;
   localparam src_type S_Q22  = 6'd39;
   localparam src_type S_Q12  = 6'd40;
   localparam src_type S_Q21  = 6'd41;
   localparam src_type S_R    = 6'd42;
   localparam src_type S_ONE  = 6'd43;
   localparam src_type S_ZERO = 6'd44;
   localparam src_type S_Y    = 6'd45;
   localparam src_type S_X1   = 6'd46;
   localparam src_type S_X2   = 6'd47;
   localparam src_type S_P0   = 6'd48;
   localparam src_type S_P1   = 6'd49;
   localparam src_type S_P2   = 6'd50;
   localparam src_type S_P3   = 6'd51;

   typedef struct packed {
      op_type  op;
      src_type dst;
      src_type sa;
      src_type sb;
   } uop_type;

   localparam pc_type LAST_PC = 7'd74;

   function automatic uop_type uop_rom(input pc_type pc);
      uop_type u;
      case (pc)
         7'd0:  u = '{OP_MUL, T_M0,  S_A11, S_X1};
         7'd1:  u = '{OP_MUL, T_M1,  S_A12, S_X2};
         7'd2:  u = '{OP_ADD, T_XP1, T_M0,  T_M1};
         7'd3:  u = '{OP_MUL, T_M0,  S_A21, S_X1};
         7'd4:  u = '{OP_MUL, T_M1,  S_A22, S_X2};
         7'd5:  u = '{OP_ADD, T_XP2, T_M0,  T_M1};
         7'd6:  u = '{OP_MUL, T_M0,  S_A11, S_P0};
         7'd7:  u = '{OP_MUL, T_M1,  S_A12, S_P2};
         7'd8:  u = '{OP_ADD, T_M11, T_M0,  T_M1};
         7'd9:  u = '{OP_MUL, T_M0,  S_A11, S_P1};
         7'd10: u = '{OP_MUL, T_M1,  S_A12, S_P3};
         7'd11: u = '{OP_ADD, T_M12, T_M0,  T_M1};
         7'd12: u = '{OP_MUL, T_M0,  S_A21, S_P0};
         7'd13: u = '{OP_MUL, T_M1,  S_A22, S_P2};
         7'd14: u = '{OP_ADD, T_M21, T_M0,  T_M1};
         7'd15: u = '{OP_MUL, T_M0,  S_A21, S_P1};
         7'd16: u = '{OP_MUL, T_M1,  S_A22, S_P3};
         7'd17: u = '{OP_ADD, T_M22, T_M0,  T_M1};
         7'd18: u = '{OP_MUL, T_M0,  T_M11, S_A11};
         7'd19: u = '{OP_MUL, T_M1,  T_M12, S_A12};
         7'd20: u = '{OP_ADD, T_DT,  T_M0,  T_M1};
         7'd21: u = '{OP_ADD, T_P11, T_DT,  S_Q11};
         7'd22: u = '{OP_MUL, T_M0,  T_M11, S_A21};
         7'd23: u = '{OP_MUL, T_M1,  T_M12, S_A22};
         7'd24: u = '{OP_ADD, T_DT,  T_M0,  T_M1};
         7'd25: u = '{OP_ADD, T_P12, T_DT,  S_Q12};
         7'd26: u = '{OP_MUL, T_M0,  T_M21, S_A11};
         7'd27: u = '{OP_MUL, T_M1,  T_M22, S_A12};
         7'd28: u = '{OP_ADD, T_DT,  T_M0,  T_M1};
         7'd29: u = '{OP_ADD, T_P21, T_DT,  S_Q21};
         7'd30: u = '{OP_MUL, T_M0,  T_M21, S_A21};
         7'd31: u = '{OP_MUL, T_M1,  T_M22, S_A22};
         7'd32: u = '{OP_ADD, T_DT,  T_M0,  T_M1};
         7'd33: u = '{OP_ADD, T_P22, T_DT,  S_Q22};
         7'd34: u = '{OP_MUL, T_M0,  T_P11, S_H1};
         7'd35: u = '{OP_MUL, T_M1,  T_P12, S_H2};
         7'd36: u = '{OP_ADD, T_U1,  T_M0,  T_M1};
         7'd37: u = '{OP_MUL, T_M0,  T_P21, S_H1};
         7'd38: u = '{OP_MUL, T_M1,  T_P22, S_H2};
         7'd39: u = '{OP_ADD, T_U2,  T_M0,  T_M1};
         7'd40: u = '{OP_MUL, T_M0,  S_H1,  T_U1};
         7'd41: u = '{OP_MUL, T_M1,  S_H2,  T_U2};
         7'd42: u = '{OP_ADD, T_DT,  T_M0,  T_M1};
         7'd43: u = '{OP_ADD, T_S,   T_DT,  S_R};
         7'd44: u = '{OP_CHK, T_S,   T_S,   T_S};
         7'd45: u = '{OP_DIV, T_K1,  T_U1,  T_S};
         7'd46: u = '{OP_DIV, T_K2,  T_U2,  T_S};
         7'd47: u = '{OP_MUL, T_M0,  S_H1,  T_XP1};
         7'd48: u = '{OP_MUL, T_M1,  S_H2,  T_XP2};
         7'd49: u = '{OP_ADD, T_HX,  T_M0,  T_M1};
         7'd50: u = '{OP_SUB, T_INN, S_Y,   T_HX};
         7'd51: u = '{OP_MUL, T_M0,  T_K1,  T_INN};
         7'd52: u = '{OP_ADD, S_X1,  T_XP1, T_M0};
         7'd53: u = '{OP_MUL, T_M0,  T_K2,  T_INN};
         7'd54: u = '{OP_ADD, S_X2,  T_XP2, T_M0};
         7'd55: u = '{OP_MUL, T_M0,  T_K1,  S_H1};
         7'd56: u = '{OP_SUB, T_I11, S_ONE, T_M0};
         7'd57: u = '{OP_MUL, T_M0,  T_K1,  S_H2};
         7'd58: u = '{OP_SUB, T_I12, S_ZERO, T_M0};
         7'd59: u = '{OP_MUL, T_M0,  T_K2,  S_H1};
         7'd60: u = '{OP_SUB, T_I21, S_ZERO, T_M0};
         7'd61: u = '{OP_MUL, T_M0,  T_K2,  S_H2};
         7'd62: u = '{OP_SUB, T_I22, S_ONE, T_M0};
         7'd63: u = '{OP_MUL, T_M0,  T_I11, T_P11};
         7'd64: u = '{OP_MUL, T_M1,  T_I12, T_P21};
         7'd65: u = '{OP_ADD, S_P0,  T_M0,  T_M1};
         7'd66: u = '{OP_MUL, T_M0,  T_I11, T_P12};
         7'd67: u = '{OP_MUL, T_M1,  T_I12, T_P22};
         7'd68: u = '{OP_ADD, S_P1,  T_M0,  T_M1};
         7'd69: u = '{OP_MUL, T_M0,  T_I21, T_P11};
         7'd70: u = '{OP_MUL, T_M1,  T_I22, T_P21};
         7'd71: u = '{OP_ADD, S_P2,  T_M0,  T_M1};
         7'd72: u = '{OP_MUL, T_M0,  T_I21, T_P12};
         7'd73: u = '{OP_MUL, T_M1,  T_I22, T_P22};
         7'd74: u = '{OP_ADD, S_P3,  T_M0,  T_M1};
         default: u = '{OP_CHK, T_S, T_S, T_S};
      endcase
      return u;
   endfunction

endpackage

>>> sv/kalman_filter_two_state_step.sv
// A load transaction goes straight to the response stage; a measurement runs 72 shared-unit
// operations, each through read, execute and write back, a sign check of the innovation
// variance and two quotients through the restoring divider; a faulting step stops at the check.
// One transaction at a time: no new request is taken while a step runs, and the next is accepted
// once the result register is free again. Synchronous active-high reset restores the default
// coefficients and zeroes the state. Depends on kf2s_pkg.
module kalman_filter_two_state_step (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  kf2s_pkg::req_type                     req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output kf2s_pkg::rsp_type                     rsp_payload,
   input  logic                                  csr_wr_en,
   input  logic [kf2s_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [kf2s_pkg::CFG_WIDTH-1:0]        csr_wdata
);
   import kf2s_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int PW = 2 * DW;
   localparam int RW = PW + 1 - FRAC_BITS;
   localparam int QW = DW + 1;

   state_type st_ff, st_in;
   pc_type    pc_ff, pc_in;

   logic [CFG_WIDTH-1:0] cfg_a1_ff, cfg_a2_ff, cfg_h_ff, cfg_qd_ff, cfg_qc_ff;
   logic [DW-2:0]        cfg_r_ff;

   val_type x1_ff, x2_ff, p0_ff, p1_ff, p2_ff, p3_ff, y_ff;
   logic    clip_ff, fault_ff, rsp_valid_ff;
   rsp_type rsp_ff;

   val_type tmp_mem [TMP_DEPTH];
   val_type rda_ff, rdb_ff;

   logic [PW-1:0]        prod_ff;
   logic signed [DW:0]   sum_ff;
   logic                 neg_ff;
   logic [DIV_STEPS-1:0] dvd_ff;
   logic [DW-1:0]        rem_ff, den_ff;
   logic [QW-1:0]        quo_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;

   uop_type uop;
   val_type opa, opb, wb_val;
   logic [DW-1:0] mag_a, mag_b;
   logic    wb_clip, req_fire;
   logic [DW:0]   trial;
   logic [QW:0]   quo_sh;

   assign uop       = uop_rom(pc_ff);
   assign req_ready = (st_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   function automatic val_type named_val(input src_type s, input val_type y,
                                         input val_type x1, input val_type x2,
                                         input val_type p0, input val_type p1,
                                         input val_type p2, input val_type p3,
                                         input logic [CFG_WIDTH-1:0] a1,
                                         input logic [CFG_WIDTH-1:0] a2,
                                         input logic [CFG_WIDTH-1:0] h,
                                         input logic [CFG_WIDTH-1:0] qd,
                                         input logic [CFG_WIDTH-1:0] qc,
                                         input logic [DW-2:0] r);
      val_type v;
      case (s)
         S_A11:   v = a1[CFG_WIDTH-1 -: DW];
         S_A12:   v = a1[DW-1:0];
         S_A21:   v = a2[CFG_WIDTH-1 -: DW];
         S_A22:   v = a2[DW-1:0];
         S_H1:    v = h[CFG_WIDTH-1 -: DW];
         S_H2:    v = h[DW-1:0];
         S_Q11:   v = qd[CFG_WIDTH-1 -: DW];
         S_Q22:   v = qd[DW-1:0];
         S_Q12:   v = qc[CFG_WIDTH-1 -: DW];
         S_Q21:   v = qc[DW-1:0];
         S_R:     v = {1'b0, r};
         S_ONE:   v = val_type'(1) <<< FRAC_BITS;
         S_Y:     v = y;
         S_X1:    v = x1;
         S_X2:    v = x2;
         S_P0:    v = p0;
         S_P1:    v = p1;
         S_P2:    v = p2;
         S_P3:    v = p3;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Signed value from a sign and a magnitude, clipped to the data range.
   function automatic logic [DW:0] from_mag(input logic neg, input logic [RW-1:0] m);
      logic [RW-1:0] lim;
      logic [DW:0]   res;
      lim = RW'(1) << (DW - 1);
      if (neg) begin
         if (m > lim) res = {1'b1, 1'b1, {(DW-1){1'b0}}};
         else         res = {1'b0, -m[DW-1:0]};
      end else begin
         if (m > lim - RW'(1)) res = {1'b1, 1'b0, {(DW-1){1'b1}}};
         else                  res = {1'b0, m[DW-1:0]};
      end
      return res;
   endfunction

   function automatic logic rda_sel_tmp(input src_type s);
      return !s[SRC_W-1];
   endfunction

   assign opa   = (rda_sel_tmp(uop.sa)) ? rda_ff :
                  named_val(uop.sa, y_ff, x1_ff, x2_ff, p0_ff, p1_ff, p2_ff, p3_ff,
                            cfg_a1_ff, cfg_a2_ff, cfg_h_ff, cfg_qd_ff, cfg_qc_ff, cfg_r_ff);
   assign opb   = (rda_sel_tmp(uop.sb)) ? rdb_ff :
                  named_val(uop.sb, y_ff, x1_ff, x2_ff, p0_ff, p1_ff, p2_ff, p3_ff,
                            cfg_a1_ff, cfg_a2_ff, cfg_h_ff, cfg_qd_ff, cfg_qc_ff, cfg_r_ff);
   assign mag_a = opa[DW-1] ? DW'(-opa) : DW'(opa);
   assign mag_b = opb[DW-1] ? DW'(-opb) : DW'(opb);

   // Restoring divider step.
   assign trial  = {rem_ff, dvd_ff[DIV_STEPS-1]};
   assign quo_sh = {quo_ff, (trial >= {1'b0, den_ff})};

   // Write-back conversion to the data range.
   always_comb begin
      logic [PW:0]   rnd_sum;
      logic [DW:0]   conv;
      rnd_sum = {1'b0, prod_ff} + ((PW+1)'(1) << (FRAC_BITS - 1));
      conv    = '0;
      case (uop.op)
         OP_MUL:  conv = from_mag(neg_ff, rnd_sum[PW:FRAC_BITS]);
         OP_DIV:  conv = from_mag(neg_ff, RW'(quo_ff));
         default: begin
            if (sum_ff[DW] != sum_ff[DW-1])
               conv = {1'b1, sum_ff[DW], {(DW-1){!sum_ff[DW]}}};
            else
               conv = {1'b0, sum_ff[DW-1:0]};
         end
      endcase
      wb_clip = conv[DW];
      wb_val  = conv[DW-1:0];
   end

   always_comb begin
      st_in = st_ff;
      pc_in = pc_ff;
      case (st_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pc_in = '0;
               st_in = req_payload.mode ? ST_RD : ST_DONE;
            end
         end
         ST_RD: st_in = ST_EX;
         ST_EX: begin
            case (uop.op)
               OP_DIV: st_in = ST_DIV;
               OP_CHK: begin
                  if (opa <= 0) begin
                     st_in = ST_DONE;
                  end else begin
                     pc_in = pc_ff + 1'b1;
                     st_in = ST_RD;
                  end
               end
               default: st_in = ST_WB;
            endcase
         end
         ST_DIV: begin
            if (cnt_ff == DIV_CNT_W'(1)) st_in = ST_WB;
         end
         ST_WB: begin
            if (pc_ff == LAST_PC) begin
               st_in = ST_DONE;
            end else begin
               pc_in = pc_ff + 1'b1;
               st_in = ST_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         pc_ff <= '0;
      end else begin
         st_ff <= st_in;
         pc_ff <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_a1_ff <= CFG_WIDTH'(1) << (CFG_WIDTH - DW + FRAC_BITS);
         cfg_a2_ff <= CFG_WIDTH'(1) << FRAC_BITS;
         cfg_h_ff  <= CFG_WIDTH'(1) << (CFG_WIDTH - DW + FRAC_BITS);
         cfg_qd_ff <= '0;
         cfg_qc_ff <= '0;
         cfg_r_ff  <= (DW-1)'(2684355);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TRANS_ROW_FIRST:  cfg_a1_ff <= csr_wdata;
            CSR_TRANS_ROW_SECOND: cfg_a2_ff <= csr_wdata;
            CSR_OBS_GAINS:        cfg_h_ff  <= csr_wdata;
            CSR_PROC_NOISE_DIAG:  cfg_qd_ff <= csr_wdata;
            CSR_PROC_NOISE_CROSS: cfg_qc_ff <= csr_wdata;
            CSR_MEAS_NOISE:       cfg_r_ff  <= csr_wdata[DW-2:0];
            default: ;
         endcase
      end
   end

   // Scratch memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (st_ff == ST_WB && rda_sel_tmp(uop.dst))
         tmp_mem[uop.dst[TMP_AW-1:0]] <= wb_val;
      rda_ff <= tmp_mem[uop.sa[TMP_AW-1:0]];
      rdb_ff <= tmp_mem[uop.sb[TMP_AW-1:0]];
   end

   // Filter state, flags and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff        <= '0;
         x2_ff        <= '0;
         p0_ff        <= '0;
         p1_ff        <= '0;
         p2_ff        <= '0;
         p3_ff        <= '0;
         clip_ff      <= 1'b0;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            clip_ff  <= 1'b0;
            fault_ff <= 1'b0;
            y_ff     <= req_payload.measurement;
            if (!req_payload.mode) begin
               x1_ff <= req_payload.init_first;
               x2_ff <= req_payload.init_second;
               p0_ff <= req_payload.init_cov_11;
               p1_ff <= req_payload.init_cov_12;
               p2_ff <= req_payload.init_cov_21;
               p3_ff <= req_payload.init_cov_22;
            end
         end
         if (st_ff == ST_EX && uop.op == OP_CHK && opa <= 0) fault_ff <= 1'b1;
         if (st_ff == ST_WB) begin
            clip_ff <= clip_ff | wb_clip;
            case (uop.dst)
               S_X1:    x1_ff <= wb_val;
               S_X2:    x2_ff <= wb_val;
               S_P0:    p0_ff <= wb_val;
               S_P1:    p1_ff <= wb_val;
               S_P2:    p2_ff <= wb_val;
               S_P3:    p3_ff <= wb_val;
               default: ;
            endcase
         end
         if (st_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff <= '{x1_ff, x2_ff, p0_ff, p1_ff, p2_ff, p3_ff, fault_ff, clip_ff};
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Shared multiplier, adder and the divider datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (st_ff == ST_EX && uop.op == OP_DIV) begin
         cnt_ff <= DIV_CNT_W'(DIV_STEPS);
      end else if (st_ff == ST_DIV) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (st_ff == ST_EX) begin
         prod_ff <= mag_a * mag_b;
         neg_ff  <= opa[DW-1] ^ (opb[DW-1] && uop.op == OP_MUL);
         if (uop.op == OP_SUB) sum_ff <= {opa[DW-1], opa} - {opb[DW-1], opb};
         else                  sum_ff <= {opa[DW-1], opa} + {opb[DW-1], opb};
         dvd_ff <= {mag_a, {FRAC_BITS{1'b0}}};
         rem_ff <= '0;
         quo_ff <= '0;
         den_ff <= opb;
      end else if (st_ff == ST_DIV) begin
         dvd_ff <= dvd_ff << 1;
         if (trial >= {1'b0, den_ff}) rem_ff <= DW'(trial - {1'b0, den_ff});
         else                         rem_ff <= trial[DW-1:0];
         // The quotient is capped just above the data range, as it only feeds a clip.
         if (quo_sh > (QW+1)'(1) << DW) quo_ff <= QW'(1) << DW;
         else                           quo_ff <= quo_sh[QW-1:0];
      end
   end

   a_div_cnt_only_in_div: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> (st_ff == ST_DIV || $past(st_ff) == ST_EX))
      else $error("divider count live outside a division");
   a_load_goes_done: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_payload.mode) |=> (st_ff == ST_DONE))
      else $error("load transaction did not finish directly");
   a_pc_in_range: assert property (@(posedge clock) disable iff (reset)
      (pc_ff <= LAST_PC))
      else $error("sequencer ran past the microprogram");
   a_fault_ends_run: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_EX && uop.op == OP_CHK && opa <= 0) |=> (st_ff == ST_DONE))
      else $error("non-positive innovation variance did not stop the step");

endmodule

>>> tb/kalman_filter_two_state_step_check.sv
// Checker for the two-state Kalman filter step: watches the request, response and register
// ports, predicts every response in fixed point and compares it field by field.
// Depends on kf2s_pkg.
module kalman_filter_two_state_step_check
   import kf2s_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_payload,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0] csr_wdata,
   output int                   fail_count,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint VAL_MAX = 64'sd2147483647;
   localparam longint VAL_MIN = -64'sd2147483648;
   localparam longint unsigned MAG_CAP = 64'd1 << 32;

   logic [CFG_WIDTH-1:0] trans_first, trans_second, gains, noise_diag, noise_cross;
   logic [30:0]          noise_r;
   longint               est [2];
   longint               cov [4];
   bit                   clipped;
   rsp_type              expected_rsp [$];

   function automatic longint clamp(longint v);
      if (v > VAL_MAX) begin
         clipped = 1'b1;
         return VAL_MAX;
      end
      if (v < VAL_MIN) begin
         clipped = 1'b1;
         return VAL_MIN;
      end
      return v;
   endfunction

   function automatic longint half(logic [31:0] x);
      return longint'(signed'(x));
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   function automatic longint from_mag(bit neg, longint unsigned m);
      if (m > MAG_CAP) m = MAG_CAP;
      return clamp(neg ? -longint'(m) : longint'(m));
   endfunction

   // Product rounded half away from zero on its magnitude.
   function automatic longint fx_mul(longint a, longint b);
      longint unsigned p;
      p = magnitude(a) * magnitude(b) + (64'd1 << (FRAC_BITS - 1));
      return from_mag((a < 0) != (b < 0), p >> FRAC_BITS);
   endfunction

   function automatic longint fx_div(longint num, longint den);
      longint unsigned q;
      q = (magnitude(num) << FRAC_BITS) / longint'(den);
      return from_mag(num < 0, q);
   endfunction

   function automatic longint fx_dot(longint a, longint b, longint c, longint d);
      return clamp(fx_mul(a, b) + fx_mul(c, d));
   endfunction

   function automatic rsp_type filter_step(req_type rq);
      rsp_type r;
      longint  a11, a12, a21, a22, h1, h2, q11, q22, q12, q21, rn, one, y;
      longint  xp1, xp2, m11, m12, m21, m22, p11, p12, p21, p22;
      longint  u1, u2, s, k1, k2, innov, i11, i12, i21, i22;
      bit      fault;
      clipped = 1'b0;
      fault   = 1'b0;
      if (!rq.mode) begin
         est[0] = half(rq.init_first);
         est[1] = half(rq.init_second);
         cov[0] = half(rq.init_cov_11);
         cov[1] = half(rq.init_cov_12);
         cov[2] = half(rq.init_cov_21);
         cov[3] = half(rq.init_cov_22);
      end else begin
         a11 = half(trans_first[63:32]);  a12 = half(trans_first[31:0]);
         a21 = half(trans_second[63:32]); a22 = half(trans_second[31:0]);
         h1  = half(gains[63:32]);        h2  = half(gains[31:0]);
         q11 = half(noise_diag[63:32]);   q22 = half(noise_diag[31:0]);
         q12 = half(noise_cross[63:32]);  q21 = half(noise_cross[31:0]);
         rn  = longint'(noise_r);
         one = longint'(1) << FRAC_BITS;
         y   = half(rq.measurement);
         xp1 = fx_dot(a11, est[0], a12, est[1]);
         xp2 = fx_dot(a21, est[0], a22, est[1]);
         m11 = fx_dot(a11, cov[0], a12, cov[2]);
         m12 = fx_dot(a11, cov[1], a12, cov[3]);
         m21 = fx_dot(a21, cov[0], a22, cov[2]);
         m22 = fx_dot(a21, cov[1], a22, cov[3]);
         p11 = clamp(fx_dot(m11, a11, m12, a12) + q11);
         p12 = clamp(fx_dot(m11, a21, m12, a22) + q12);
         p21 = clamp(fx_dot(m21, a11, m22, a12) + q21);
         p22 = clamp(fx_dot(m21, a21, m22, a22) + q22);
         u1  = fx_dot(p11, h1, p12, h2);
         u2  = fx_dot(p21, h1, p22, h2);
         s   = clamp(fx_dot(h1, u1, h2, u2) + rn);
         if (s <= 0) begin
            fault = 1'b1;
         end else begin
            k1     = fx_div(u1, s);
            k2     = fx_div(u2, s);
            innov  = clamp(y - fx_dot(h1, xp1, h2, xp2));
            est[0] = clamp(xp1 + fx_mul(k1, innov));
            est[1] = clamp(xp2 + fx_mul(k2, innov));
            i11    = clamp(one - fx_mul(k1, h1));
            i12    = clamp(-fx_mul(k1, h2));
            i21    = clamp(-fx_mul(k2, h1));
            i22    = clamp(one - fx_mul(k2, h2));
            cov[0] = fx_dot(i11, p11, i12, p21);
            cov[1] = fx_dot(i11, p12, i12, p22);
            cov[2] = fx_dot(i21, p11, i22, p21);
            cov[3] = fx_dot(i21, p12, i22, p22);
         end
      end
      r.est_first  = est[0][31:0];
      r.est_second = est[1][31:0];
      r.out_cov_11 = cov[0][31:0];
      r.out_cov_12 = cov[1][31:0];
      r.out_cov_21 = cov[2][31:0];
      r.out_cov_22 = cov[3][31:0];
      r.div_fault  = fault;
      r.saturated  = clipped;
      return r;
   endfunction

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         trans_first  <= 64'h1000_0000_0000_0000;
         trans_second <= 64'h0000_0000_1000_0000;
         gains        <= 64'h1000_0000_0000_0000;
         noise_diag   <= '0;
         noise_cross  <= '0;
         noise_r      <= 31'd2684355;
         est = '{0, 0};
         cov = '{0, 0, 0, 0};
         expected_rsp.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TRANS_ROW_FIRST:  trans_first  <= csr_wdata;
               CSR_TRANS_ROW_SECOND: trans_second <= csr_wdata;
               CSR_OBS_GAINS:        gains        <= csr_wdata;
               CSR_PROC_NOISE_DIAG:  noise_diag   <= csr_wdata;
               CSR_PROC_NOISE_CROSS: noise_cross  <= csr_wdata;
               CSR_MEAS_NOISE:       noise_r      <= csr_wdata[30:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) expected_rsp.push_back(filter_step(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected response transaction %h", $time, rsp_payload);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               compare_field("est_first",  want.est_first,  rsp_payload.est_first);
               compare_field("est_second", want.est_second, rsp_payload.est_second);
               compare_field("out_cov_11", want.out_cov_11, rsp_payload.out_cov_11);
               compare_field("out_cov_12", want.out_cov_12, rsp_payload.out_cov_12);
               compare_field("out_cov_21", want.out_cov_21, rsp_payload.out_cov_21);
               compare_field("out_cov_22", want.out_cov_22, rsp_payload.out_cov_22);
               compare_field("div_fault",  want.div_fault,  rsp_payload.div_fault);
               compare_field("saturated",  want.saturated,  rsp_payload.saturated);
            end
         end
      end
      pending <= expected_rsp.size();
   end

endmodule

>>> tb/kalman_filter_two_state_step_test.sv
// Top of the testbench for the two-state Kalman filter step: clock, reset, register writes,
// request stimulus with idling phases, response stalls, watchdog and verdict.
// Depends on kf2s_pkg, kalman_filter_two_state_step and kalman_filter_two_state_step_check.
module kalman_filter_two_state_step_test;
   import kf2s_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 20000;
   localparam int HOLD_CYCLES = 1500;
   localparam logic [31:0] FX_ONE = 32'h1000_0000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid, req_ready;
   req_type              req_payload;
   logic                 rsp_valid, rsp_ready;
   rsp_type              rsp_payload;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_WIDTH-1:0] csr_wdata;
   int                   fail_count, pending;
   int                   send_idle_pct, recv_stall_pct;
   bit                   hold_rsp;
   int                   quiet;

   kalman_filter_two_state_step u_dut (.*);

   kalman_filter_two_state_step_check u_check (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Mixes full-range values with values of a few units so that the filter also runs sanely.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return $urandom();
         default: return $urandom_range(0, 32'h6000_0000) - 32'h3000_0000;
      endcase
   endfunction

   function automatic req_type pick_item(bit mode);
      req_type t;
      t.mode        = mode;
      t.measurement = pick_value();
      t.init_first  = pick_value();
      t.init_second = pick_value();
      // Loaded covariance is mostly a small positive variance so that steps get past the gain.
      t.init_cov_11 = ($urandom_range(0, 3) == 0) ? pick_value() : $urandom_range(0, 32'h2000_0000);
      t.init_cov_12 = pick_value();
      t.init_cov_21 = pick_value();
      t.init_cov_22 = ($urandom_range(0, 3) == 0) ? pick_value() : $urandom_range(0, 32'h2000_0000);
      return t;
   endfunction

   task automatic send(req_type t);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= t;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_WIDTH-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_coeffs(logic [63:0] a1, logic [63:0] a2, logic [63:0] h,
                              logic [63:0] qd, logic [63:0] qc, logic [30:0] r);
      write_reg(CSR_TRANS_ROW_FIRST, a1);
      write_reg(CSR_TRANS_ROW_SECOND, a2);
      write_reg(CSR_OBS_GAINS, h);
      write_reg(CSR_PROC_NOISE_DIAG, qd);
      write_reg(CSR_PROC_NOISE_CROSS, qc);
      write_reg(CSR_MEAS_NOISE, {33'd0, r});
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] pick_pair();
      return {pick_value(), pick_value()};
   endfunction

   task automatic load(logic [31:0] x1, logic [31:0] x2, logic [31:0] c11, logic [31:0] c12,
                       logic [31:0] c21, logic [31:0] c22);
      req_type t;
      t = pick_item(1'b0);
      t.init_first  = x1;
      t.init_second = x2;
      t.init_cov_11 = c11;
      t.init_cov_12 = c12;
      t.init_cov_21 = c21;
      t.init_cov_22 = c22;
      send(t);
   endtask

   task automatic measure(logic [31:0] y);
      req_type t;
      t = pick_item(1'b1);
      t.measurement = y;
      send(t);
   endtask

   // Response side: random stalls, plus one long hold-off when asked.
   initial begin
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            @(posedge clock);
         end
      end
   end

   initial begin
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("kalman_filter_two_state_step_test failed");
            $finish;
         end
      end
   end

   initial begin
      int mode_sel;
      req_valid      <= 1'b0;
      req_payload    <= '0;
      csr_wr_en      <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      reset          <= 1'b1;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_rsp       = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset coefficients: zero state, extremes, a fault.
      measure(32'h0000_0000);
      load(FX_ONE, 32'h0, FX_ONE, 32'h0, 32'h0, FX_ONE);
      measure(32'h2000_0000);
      measure(32'h7FFF_FFFF);
      measure(32'h8000_0000);
      load(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
           32'h8000_0000);
      measure(32'h8000_0000);
      load(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
           32'h7FFF_FFFF);
      measure(32'h7FFF_FFFF);
      // A negative variance makes the innovation variance negative, so the step must hold.
      load(FX_ONE, FX_ONE, 32'hF000_0000, 32'h0, 32'h0, 32'h0);
      measure(32'h0100_0000);
      drain();

      // Coupled coefficients, smallest noise, then a zero innovation variance borderline.
      load_coeffs({32'h0F00_0000, 32'h0100_0000}, {32'hFF00_0000, 32'h0E00_0000},
                  {FX_ONE, 32'h0800_0000}, {32'h0010_0000, 32'h0010_0000},
                  {32'h0000_1000, 32'hFFFF_F000}, 31'd1);
      load(32'h0400_0000, 32'hFC00_0000, 32'h0800_0000, 32'h0100_0000, 32'h0100_0000,
           32'h0800_0000);
      repeat (4) measure(pick_value());
      load(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      measure(32'h1000_0000);
      load(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
      measure(32'h1000_0000);
      drain();

      // Random phases: each pairs one idling pattern with one coefficient setting.
      for (int phase = 0; phase < 8; phase++) begin
         mode_sel = phase % 4;
         send_idle_pct  = (mode_sel == 1) ? 87 : (mode_sel == 3) ? 33 : 0;
         recv_stall_pct = (mode_sel == 2) ? 87 : (mode_sel == 3) ? 33 : 0;
         case (phase)
            1: load_coeffs('1, '1, '1, '1, '1, 31'h7FFF_FFFF);
            2: load_coeffs({2{32'h7FFF_FFFF}}, {2{32'h8000_0000}}, {32'h8000_0000, 32'h7FFF_FFFF},
                           {2{32'h8000_0000}}, {2{32'h7FFF_FFFF}}, 31'd1);
            3: load_coeffs({FX_ONE, 32'h0}, {32'h0, FX_ONE}, {FX_ONE, 32'h0}, '0, '0, 31'd2684355);
            default: load_coeffs(pick_pair(), pick_pair(), pick_pair(), pick_pair(), pick_pair(),
                                 ($urandom_range(0, 1) == 0) ? 31'($urandom_range(1, 32'h7FFF_FFFF))
                                                             : 31'($urandom_range(1, 32'h0100_0000)));
         endcase
         for (int n = 0; n < 170; n++) begin
            if (phase == 5 && n == 20) hold_rsp = 1'b1;
            // Mostly runs of steps after a fresh load, with the odd stray load.
            send(pick_item((n % 12 == 0) ? 1'b0 : ($urandom_range(0, 19) != 0)));
         end
         drain();
      end

      repeat (400) @(posedge clock);
      if (fail_count == 0) begin
         $display("kalman_filter_two_state_step_test passed");
      end else begin
         $display("kalman_filter_two_state_step_test failed");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/kf2s_pkg.sv
sv/kalman_filter_two_state_step.sv
tb/kalman_filter_two_state_step_check.sv
tb/kalman_filter_two_state_step_test.sv
